// ===== sv/ile_pkg.sv =====
// Shared constants, types and codes of the indexed list engine.
`default_nettype none

package ile_pkg;

    // Store geometry and field widths.
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 4;
    localparam int STAT_W   = 2;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // Command codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 4'd0,
        K_INS_BACK  = 4'd1,
        K_INS_AT    = 4'd2,
        K_DEL_FRONT = 4'd3,
        K_DEL_BACK  = 4'd4,
        K_DEL_AT    = 4'd5,
        K_GET       = 4'd6,
        K_SET       = 4'd7,
        K_FIND      = 4'd8,
        K_COUNT     = 4'd9,
        K_DEL_FIRST = 4'd10,
        K_DEL_ALL   = 4'd11,
        K_REVERSE   = 4'd12,
        K_CLEAR     = 4'd13
    } t_kind;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_PLACE,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_DONE
    } t_state;

    // What the walk does with each element it reads.
    typedef enum logic [2:0] {
        W_SHIFT_UP,
        W_COMPACT,
        W_FIND,
        W_COUNT,
        W_GET
    } t_walk;

    // Write request into the element store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_word            data;
    } t_mem_wr;

endpackage

`default_nettype wire

// ===== sv/ile_if.sv =====
// Command and response channel interfaces of the indexed list engine.
`default_nettype none

interface ile_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [ile_pkg::KIND_W-1:0] kind;
    logic [ile_pkg::CNT_W-1:0]  position;
    logic signed [31:0]         operand_value;

    modport source (output valid, output kind, output position, output operand_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input operand_value,
                    output ready);
endinterface

interface ile_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ile_pkg::STAT_W-1:0] status;
    logic signed [31:0]         read_value;
    logic [ile_pkg::CNT_W-1:0]  result_number;
    logic                       found;
    logic [ile_pkg::CNT_W-1:0]  list_length;
    logic                       list_is_empty;

    modport source (output valid, output status, output read_value, output result_number,
                    output found, output list_length, output list_is_empty,
                    input ready);
    modport sink   (input valid, input status, input read_value, input result_number,
                    input found, input list_length, input list_is_empty,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ile_store.sv =====
// Element store: one write port and one registered read port.
`default_nettype none

module ile_store (
    input  wire                            i_clk,
    input  wire  ile_pkg::t_mem_wr         i_wr,
    input  wire  [ile_pkg::IDX_W-1:0]      i_rd_addr,
    output ile_pkg::t_word                 o_rd_data
);

    ile_pkg::t_word r_mem [ile_pkg::CAPACITY];
    ile_pkg::t_word r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/indexed_list_engine.sv =====
// Top level of the indexed list engine: command decode, walk sequencer and response register.
//
//  channel | dir | beat contents                                           | handshake
//  i_cmd   | in  | kind, position, operand_value                           | valid/ready
//  o_rsp   | out | status, read_value, result_number, found, list_length,  | valid/ready
//          |     | list_is_empty                                           |
//
// One command is worked on at a time; i_cmd.ready is high only while the sequencer is idle.
// Walks go through the single store read port one element per cycle, and a find walk stops
// at its first hit. Reverse reads the low and then the high element of each pair and writes
// them back swapped, low side first.
// A finished response waits in the output register while the next command is accepted;
// a command that finishes while that register is still full waits until it drains.
// Reset (synchronous, active low) empties the list; store contents need no clearing.
`default_nettype none

module indexed_list_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ile_cmd_if.sink    i_cmd,
    ile_rsp_if.source  o_rsp
);

    localparam int IDX_W = ile_pkg::IDX_W;
    localparam int CNT_W = ile_pkg::CNT_W;

    // Sequencer and datapath registers.
    ile_pkg::t_state  r_state, n_state;
    ile_pkg::t_kind   r_kind, n_kind;
    ile_pkg::t_walk   r_mode, n_mode;
    ile_pkg::t_status r_status, n_status;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos, n_pos;
    ile_pkg::t_word   r_val, n_val;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic             r_pv, n_pv;
    logic [CNT_W-1:0] r_pidx, n_pidx;
    logic [CNT_W-1:0] r_wj, n_wj;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_num, n_num;
    ile_pkg::t_word   r_rd, n_rd;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    ile_pkg::t_word   r_tmp, n_tmp;

    // Response register.
    logic             r_o_valid, n_o_valid;
    ile_pkg::t_status r_o_status, n_o_status;
    ile_pkg::t_word   r_o_read, n_o_read;
    logic [CNT_W-1:0] r_o_num, n_o_num;
    logic             r_o_found, n_o_found;
    logic [CNT_W-1:0] r_o_len, n_o_len;

    // Store interface.
    ile_pkg::t_mem_wr mem_wr;
    logic [IDX_W-1:0] rd_addr;
    ile_pkg::t_word   rd_data;

    // Command decode results.
    ile_pkg::t_state  d_next;
    ile_pkg::t_status d_status;
    ile_pkg::t_walk   d_mode;
    logic [CNT_W-1:0] d_ptr;
    logic [CNT_W-1:0] d_rem;
    logic [CNT_W-1:0] d_pos;
    logic [CNT_W-1:0] d_count;
    logic             d_write;

    logic             cmd_acc;
    logic             is_full;
    logic [CNT_W-1:0] ins_idx;
    logic             walk_done;
    logic             key_match;
    logic             find_hit;
    logic             skip_by_index;
    logic             skip_elem;
    logic             rsp_free;
    logic             rev_more;
    logic             num_kind;

    ile_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Shared conditions.
    assign cmd_acc   = i_cmd.valid && i_cmd.ready;
    assign is_full   = (r_count == CNT_W'(ile_pkg::CAPACITY));
    assign walk_done = (r_rem == '0) && !r_pv;
    assign key_match = (rd_data == r_val);
    assign find_hit  = r_pv && (r_mode == ile_pkg::W_FIND) && key_match;
    assign rsp_free  = !r_o_valid || o_rsp.ready;
    assign rev_more  = (CNT_W'(r_lo) + CNT_W'(2)) < CNT_W'(r_hi);
    assign skip_by_index = (r_kind == ile_pkg::K_DEL_FRONT) || (r_kind == ile_pkg::K_DEL_AT);
    assign skip_elem = skip_by_index ? (r_pidx == r_pos)
                     : (key_match && ((r_kind == ile_pkg::K_DEL_ALL) || !r_found));
    assign num_kind  = (r_kind == ile_pkg::K_FIND) || (r_kind == ile_pkg::K_COUNT) ||
                       (r_kind == ile_pkg::K_DEL_FIRST) || (r_kind == ile_pkg::K_DEL_ALL);
    assign ins_idx   = (ile_pkg::t_kind'(i_cmd.kind) == ile_pkg::K_INS_FRONT) ? '0
                     : (ile_pkg::t_kind'(i_cmd.kind) == ile_pkg::K_INS_BACK) ? r_count
                     : i_cmd.position;

    // Decode of the incoming command against the current length.
    always_comb begin
        d_next   = ile_pkg::S_DONE;
        d_status = ile_pkg::ST_OK;
        d_mode   = ile_pkg::W_GET;
        d_ptr    = '0;
        d_rem    = '0;
        d_pos    = i_cmd.position;
        d_count  = r_count;
        d_write  = 1'b0;
        unique case (ile_pkg::t_kind'(i_cmd.kind))
            ile_pkg::K_INS_FRONT, ile_pkg::K_INS_BACK, ile_pkg::K_INS_AT: begin
                if (is_full) begin
                    d_status = ile_pkg::ST_FULL;
                end else if (ins_idx > r_count) begin
                    d_status = ile_pkg::ST_RANGE;
                end else begin
                    d_pos  = ins_idx;
                    d_mode = ile_pkg::W_SHIFT_UP;
                    d_ptr  = r_count - CNT_W'(1);
                    d_rem  = r_count - ins_idx;
                    d_next = (ins_idx == r_count) ? ile_pkg::S_PLACE : ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_DEL_FRONT: begin
                if (r_count == '0) begin
                    d_status = ile_pkg::ST_EMPTY;
                end else begin
                    d_pos  = '0;
                    d_mode = ile_pkg::W_COMPACT;
                    d_rem  = r_count;
                    d_next = ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_DEL_BACK: begin
                if (r_count == '0) begin
                    d_status = ile_pkg::ST_EMPTY;
                end else begin
                    d_count = r_count - CNT_W'(1);
                end
            end
            ile_pkg::K_DEL_AT: begin
                if (i_cmd.position >= r_count) begin
                    d_status = ile_pkg::ST_RANGE;
                end else begin
                    d_mode = ile_pkg::W_COMPACT;
                    d_ptr  = i_cmd.position;
                    d_rem  = r_count - i_cmd.position;
                    d_next = ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_GET: begin
                if (i_cmd.position >= r_count) begin
                    d_status = ile_pkg::ST_RANGE;
                end else begin
                    d_mode = ile_pkg::W_GET;
                    d_ptr  = i_cmd.position;
                    d_rem  = CNT_W'(1);
                    d_next = ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_SET: begin
                if (i_cmd.position >= r_count) begin
                    d_status = ile_pkg::ST_RANGE;
                end else begin
                    d_write = 1'b1;
                end
            end
            ile_pkg::K_FIND, ile_pkg::K_COUNT: begin
                if (r_count != '0) begin
                    d_mode = (ile_pkg::t_kind'(i_cmd.kind) == ile_pkg::K_FIND) ?
                             ile_pkg::W_FIND : ile_pkg::W_COUNT;
                    d_rem  = r_count;
                    d_next = ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_DEL_FIRST, ile_pkg::K_DEL_ALL: begin
                if (r_count != '0) begin
                    d_mode = ile_pkg::W_COMPACT;
                    d_rem  = r_count;
                    d_next = ile_pkg::S_WALK;
                end
            end
            ile_pkg::K_REVERSE: begin
                if (r_count > CNT_W'(1)) begin
                    d_next = ile_pkg::S_REV_RD_LO;
                end
            end
            ile_pkg::K_CLEAR: begin
                d_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_state = d_next;
                end
            end
            ile_pkg::S_WALK: begin
                if (find_hit) begin
                    n_state = ile_pkg::S_DONE;
                end else if (walk_done) begin
                    n_state = (r_mode == ile_pkg::W_SHIFT_UP) ? ile_pkg::S_PLACE
                                                              : ile_pkg::S_DONE;
                end
            end
            ile_pkg::S_PLACE:     n_state = ile_pkg::S_DONE;
            ile_pkg::S_REV_RD_LO: n_state = ile_pkg::S_REV_RD_HI;
            ile_pkg::S_REV_RD_HI: n_state = ile_pkg::S_REV_WR_LO;
            ile_pkg::S_REV_WR_LO: n_state = ile_pkg::S_REV_WR_HI;
            ile_pkg::S_REV_WR_HI: begin
                n_state = rev_more ? ile_pkg::S_REV_RD_LO : ile_pkg::S_DONE;
            end
            ile_pkg::S_DONE: begin
                if (rsp_free) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            default: n_state = ile_pkg::S_IDLE;
        endcase
    end

    // Datapath, store access and response register.
    always_comb begin
        n_kind     = r_kind;
        n_mode     = r_mode;
        n_status   = r_status;
        n_count    = r_count;
        n_pos      = r_pos;
        n_val      = r_val;
        n_ptr      = r_ptr;
        n_rem      = r_rem;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_wj       = r_wj;
        n_found    = r_found;
        n_num      = r_num;
        n_rd       = r_rd;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_tmp      = r_tmp;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_read   = r_o_read;
        n_o_num    = r_o_num;
        n_o_found  = r_o_found;
        n_o_len    = r_o_len;
        mem_wr     = '{en: 1'b0, addr: '0, data: '0};
        rd_addr    = r_ptr[IDX_W-1:0];

        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_kind   = ile_pkg::t_kind'(i_cmd.kind);
                    n_mode   = d_mode;
                    n_status = d_status;
                    n_count  = d_count;
                    n_pos    = d_pos;
                    n_val    = i_cmd.operand_value;
                    n_ptr    = d_ptr;
                    n_rem    = d_rem;
                    n_wj     = d_ptr;
                    n_found  = 1'b0;
                    n_num    = '0;
                    n_rd     = '0;
                    n_lo     = '0;
                    n_hi     = IDX_W'(r_count - CNT_W'(1));
                    if (d_write) begin
                        mem_wr = '{en: 1'b1, addr: i_cmd.position[IDX_W-1:0],
                                   data: i_cmd.operand_value};
                    end
                end
            end
            ile_pkg::S_WALK: begin
                // Issue the next read of the walk.
                if (r_rem != '0) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ptr;
                    n_rem  = r_rem - CNT_W'(1);
                    n_ptr  = (r_mode == ile_pkg::W_SHIFT_UP) ? r_ptr - CNT_W'(1)
                                                             : r_ptr + CNT_W'(1);
                end
                // Act on the element that the previous read returned.
                if (r_pv) begin
                    case (r_mode)
                        ile_pkg::W_SHIFT_UP: begin
                            mem_wr = '{en: 1'b1, addr: IDX_W'(r_pidx + CNT_W'(1)),
                                       data: rd_data};
                        end
                        ile_pkg::W_COMPACT: begin
                            if (skip_elem) begin
                                n_num = r_num + CNT_W'(1);
                                if (r_kind == ile_pkg::K_DEL_FIRST) begin
                                    n_found = 1'b1;
                                end
                            end else begin
                                mem_wr = '{en: 1'b1, addr: r_wj[IDX_W-1:0], data: rd_data};
                                n_wj   = r_wj + CNT_W'(1);
                            end
                        end
                        ile_pkg::W_FIND: begin
                            if (key_match) begin
                                n_found = 1'b1;
                                n_num   = r_pidx;
                            end
                        end
                        ile_pkg::W_COUNT: begin
                            if (key_match) begin
                                n_num = r_num + CNT_W'(1);
                            end
                        end
                        default: begin
                            n_rd = rd_data;
                        end
                    endcase
                end
                // A compaction ends with the write index as the new length.
                if (walk_done && (r_mode == ile_pkg::W_COMPACT)) begin
                    n_count = r_wj;
                end
            end
            ile_pkg::S_PLACE: begin
                mem_wr  = '{en: 1'b1, addr: r_pos[IDX_W-1:0], data: r_val};
                n_count = r_count + CNT_W'(1);
            end
            ile_pkg::S_REV_RD_LO: begin
                rd_addr = r_lo;
            end
            ile_pkg::S_REV_RD_HI: begin
                rd_addr = r_hi;
                n_tmp   = rd_data;
            end
            ile_pkg::S_REV_WR_LO: begin
                mem_wr = '{en: 1'b1, addr: r_lo, data: rd_data};
            end
            ile_pkg::S_REV_WR_HI: begin
                mem_wr = '{en: 1'b1, addr: r_hi, data: r_tmp};
                n_lo   = r_lo + IDX_W'(1);
                n_hi   = r_hi - IDX_W'(1);
            end
            ile_pkg::S_DONE: begin
                if (rsp_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_read   = r_rd;
                    n_o_num    = num_kind ? r_num : '0;
                    n_o_found  = r_found;
                    n_o_len    = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ile_pkg::S_IDLE;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_mode     <= n_mode;
        r_status   <= n_status;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_ptr      <= n_ptr;
        r_rem      <= n_rem;
        r_pidx     <= n_pidx;
        r_wj       <= n_wj;
        r_found    <= n_found;
        r_num      <= n_num;
        r_rd       <= n_rd;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_tmp      <= n_tmp;
        r_o_status <= n_o_status;
        r_o_read   <= n_o_read;
        r_o_num    <= n_o_num;
        r_o_found  <= n_o_found;
        r_o_len    <= n_o_len;
    end

    // Channel outputs.
    assign i_cmd.ready         = (r_state == ile_pkg::S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.read_value    = r_o_read;
    assign o_rsp.result_number = r_o_num;
    assign o_rsp.found         = r_o_found;
    assign o_rsp.list_length   = r_o_len;
    assign o_rsp.list_is_empty = (r_o_len == '0);

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state != ile_pkg::S_IDLE))
        else $error("sequencer stayed idle after accepting a command");

    // An insert walk only runs when the store has room.
    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ile_pkg::S_WALK) && (r_mode == ile_pkg::W_SHIFT_UP))
        |-> (r_count < CNT_W'(ile_pkg::CAPACITY)))
        else $error("insert walk started on a full list");

    // A finished command lands in an empty response register at once.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ile_pkg::S_DONE) && !r_o_valid) |=> r_o_valid)
        else $error("response was not loaded");

    // The length never exceeds the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ile_pkg::S_DONE) |-> (r_count <= CNT_W'(ile_pkg::CAPACITY)))
        else $error("list length beyond capacity");

endmodule

`default_nettype wire

// ===== test/tb_indexed_list_engine.sv =====
// Self-checking testbench of the indexed list engine with its own list predictor.
`default_nettype none

module tb_indexed_list_engine;
    import ile_pkg::*;

    // Run geometry.
    localparam int DIRECTED_ROOM = 25;
    localparam int RANDOM_ITEMS  = 800;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 600;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 400;

    // Command codes outside the defined set; the block must treat them as no-ops.
    localparam logic [KIND_W-1:0] K_SPARE_LO = 4'd14;
    localparam logic [KIND_W-1:0] K_SPARE_HI = 4'd15;

    // Shapes of random command bursts.
    localparam int BURST_GROW   = 0;
    localparam int BURST_MIX    = 1;
    localparam int BURST_SHRINK = 2;

    localparam t_word W_MAX = 32'sh7FFF_FFFF;
    localparam t_word W_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  position;
        t_word             operand;
    } t_list_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_word             read_value;
        logic [CNT_W-1:0]  number;
        logic              found;
        logic [CNT_W-1:0]  length;
        logic              empty;
    } t_list_reply;

    logic i_clk;
    logic i_rst_n;

    ile_cmd_if cmd_ch ();
    ile_rsp_if rsp_ch ();

    indexed_list_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Predictor state: a private copy of the list.
    t_word list_mem [CAPACITY];
    int    list_len;

    t_list_cmd   pending_cmds[$];
    t_list_reply expected_replies[$];
    t_list_cmd   in_flight;
    t_list_reply got_reply;
    t_list_reply want_reply;

    int cmd_total;
    int accepted_cmds;
    int reply_beats;
    int err_count;
    int cycle_count;
    int hold_left;
    bit hold_done;
    int gen_len;
    t_word key_pool [8];

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Report and count one mismatch.
    task automatic note_error(input string msg);
        $display("ERROR: reply beat %0d: %s", reply_beats, msg);
        err_count++;
    endtask

    // Open a slot at idx by moving later entries one place back.
    function automatic void list_insert(input int idx, input t_word v);
        for (int i = list_len; i > idx; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[idx] = v;
        list_len++;
    endfunction

    // Close the slot at idx by moving later entries one place forward.
    function automatic void list_remove(input int idx);
        for (int i = idx; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
    endfunction

    // Apply one command to the private list and return the reply it should produce.
    function automatic t_list_reply apply_list_cmd(input t_list_cmd c);
        t_list_reply r;
        int          pos;
        int          keep;
        int          lo;
        int          hi;
        t_word       tmp;
        r   = '0;
        pos = int'(c.position);
        case (c.kind)
            K_INS_FRONT: begin
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else list_insert(0, c.operand);
            end
            K_INS_BACK: begin
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else list_insert(list_len, c.operand);
            end
            K_INS_AT: begin
                // The full check comes before the index check.
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else if (pos > list_len) r.status = ST_RANGE;
                else list_insert(pos, c.operand);
            end
            K_DEL_FRONT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_remove(0);
            end
            K_DEL_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            K_DEL_AT: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else list_remove(pos);
            end
            K_GET: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else r.read_value = list_mem[pos];
            end
            K_SET: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else list_mem[pos] = c.operand;
            end
            K_FIND: begin
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == c.operand) begin
                        r.found  = 1'b1;
                        r.number = CNT_W'(i);
                        break;
                    end
                end
            end
            K_COUNT: begin
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == c.operand) r.number++;
            end
            K_DEL_FIRST: begin
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == c.operand) begin
                        list_remove(i);
                        r.found  = 1'b1;
                        r.number = CNT_W'(1);
                        break;
                    end
                end
            end
            K_DEL_ALL: begin
                // Compact the survivors toward the front.
                keep = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == c.operand) r.number++;
                    else begin
                        list_mem[keep] = list_mem[i];
                        keep++;
                    end
                end
                list_len = keep;
            end
            K_REVERSE: begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi) begin
                    tmp          = list_mem[lo];
                    list_mem[lo] = list_mem[hi];
                    list_mem[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            K_CLEAR: list_len = 0;
            default: ;
        endcase
        r.length = CNT_W'(list_len);
        r.empty  = (list_len == 0);
        return r;
    endfunction

    // Queue one command and keep a rough idea of the list length for aiming positions.
    task automatic add_cmd(input logic [KIND_W-1:0] k, input int pos, input t_word v);
        t_list_cmd c;
        c.kind     = k;
        c.position = CNT_W'(pos);
        c.operand  = v;
        pending_cmds.insert(pending_cmds.size(), c);
        case (k)
            K_INS_FRONT, K_INS_BACK: if (gen_len < CAPACITY) gen_len++;
            K_INS_AT:    if (gen_len < CAPACITY && pos <= gen_len) gen_len++;
            K_DEL_FRONT, K_DEL_BACK: if (gen_len > 0) gen_len--;
            K_DEL_AT:    if (pos < gen_len) gen_len--;
            K_CLEAR:     gen_len = 0;
            default: ;
        endcase
    endtask

    // Half the values come from a small pool so that searches and key deletes hit.
    function automatic t_word pick_value();
        if ($urandom_range(1) == 0) return $urandom;
        return key_pool[$urandom_range(7)];
    endfunction

    // Mostly in range, sometimes just past the end, sometimes anywhere in the field.
    function automatic int pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(gen_len);
        if (r < 90) return gen_len + $urandom_range(1);
        return $urandom_range(511);
    endfunction

    function automatic logic [KIND_W-1:0] pick_insert_kind();
        case ($urandom_range(2))
            0:       return K_INS_FRONT;
            1:       return K_INS_BACK;
            default: return K_INS_AT;
        endcase
    endfunction

    // Any command; clear and the spare codes are kept rare.
    function automatic logic [KIND_W-1:0] pick_any_kind();
        int r;
        r = $urandom_range(99);
        if (r < 2) return K_CLEAR;
        if (r < 4) return ($urandom_range(1) == 0) ? K_SPARE_LO : K_SPARE_HI;
        return KIND_W'($urandom_range(K_REVERSE));
    endfunction

    task automatic gen_burst(input int mode, input int n);
        logic [KIND_W-1:0] k;
        int                r;
        repeat (n) begin
            r = $urandom_range(99);
            if (mode == BURST_GROW && r < 70) begin
                k = pick_insert_kind();
            end else if (mode == BURST_SHRINK && r < 70) begin
                case ($urandom_range(4))
                    0:       k = K_DEL_FRONT;
                    1:       k = K_DEL_BACK;
                    2:       k = K_DEL_AT;
                    3:       k = K_DEL_FIRST;
                    default: k = K_DEL_ALL;
                endcase
            end else begin
                k = pick_any_kind();
            end
            add_cmd(k, pick_pos(), pick_value());
        end
    endtask

    // Idle rates by phase: sender light and receiver heavy, then swapped, then none.
    function automatic int phase_now();
        return (cmd_total == 0) ? 0 : (accepted_cmds * 3) / cmd_total;
    endfunction

    // Command driver: predicts each accepted beat and offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid  <= 1'b0;
            accepted_cmds <= 0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_ch.valid) begin
                expected_replies.insert(expected_replies.size(), apply_list_cmd(in_flight));
                accepted_cmds <= accepted_cmds + 1;
            end
            if (pending_cmds.size() != 0 &&
                $urandom_range(99) >= ((phase_now() == 0) ? 13 :
                                       (phase_now() == 1) ? 88 : 0)) begin
                in_flight              = pending_cmds.pop_front();
                cmd_ch.valid          <= 1'b1;
                cmd_ch.kind           <= in_flight.kind;
                cmd_ch.position       <= in_flight.position;
                cmd_ch.operand_value  <= in_flight.operand;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off late in the run, so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_cmds >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Reply monitor: each beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_reply.status     = rsp_ch.status;
                got_reply.read_value = rsp_ch.read_value;
                got_reply.number     = rsp_ch.result_number;
                got_reply.found      = rsp_ch.found;
                got_reply.length     = rsp_ch.list_length;
                got_reply.empty      = rsp_ch.list_is_empty;
                if (expected_replies.size() == 0) begin
                    note_error("reply beat with no command waiting for it");
                end else begin
                    want_reply = expected_replies.pop_front();
                    if (got_reply.status !== want_reply.status)
                        note_error($sformatf("status %0d, expected %0d",
                                             got_reply.status, want_reply.status));
                    if (got_reply.read_value !== want_reply.read_value)
                        note_error($sformatf("read_value %0d, expected %0d",
                                             got_reply.read_value, want_reply.read_value));
                    if (got_reply.number !== want_reply.number)
                        note_error($sformatf("result_number %0d, expected %0d",
                                             got_reply.number, want_reply.number));
                    if (got_reply.found !== want_reply.found)
                        note_error($sformatf("found %0d, expected %0d",
                                             got_reply.found, want_reply.found));
                    if (got_reply.length !== want_reply.length)
                        note_error($sformatf("list_length %0d, expected %0d",
                                             got_reply.length, want_reply.length));
                    if (got_reply.empty !== want_reply.empty)
                        note_error($sformatf("list_is_empty %0d, expected %0d",
                                             got_reply.empty, want_reply.empty));
                end
                reply_beats++;
            end
            rsp_ch.ready <= (hold_left == 0) &&
                            ($urandom_range(99) >= ((phase_now() == 0) ? 88 :
                                                    (phase_now() == 1) ? 13 : 0));
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = K_INS_FRONT;
        cmd_ch.position      = '0;
        cmd_ch.operand_value = '0;
        rsp_ch.ready         = 1'b0;
        list_len      = 0;
        gen_len       = 0;
        accepted_cmds = 0;
        reply_beats   = 0;
        err_count     = 0;
        cycle_count   = 0;
        cmd_total     = 0;
        key_pool      = '{32'sd0, -32'sd1, 32'sd1, W_MAX, W_MIN, 32'sd7,
                          32'sh5A5A_5A5A, -32'sd100};

        // Directed: empty list cases first, then a short list built from the extremes.
        add_cmd(K_DEL_FRONT, 0, 0);
        add_cmd(K_DEL_BACK, 0, 0);
        add_cmd(K_GET, 0, 0);
        add_cmd(K_FIND, 0, 0);
        add_cmd(K_COUNT, 0, 0);
        add_cmd(K_DEL_FIRST, 0, 0);
        add_cmd(K_DEL_ALL, 0, 0);
        add_cmd(K_REVERSE, 0, 0);
        add_cmd(K_CLEAR, 0, 0);
        add_cmd(K_INS_AT, 1, 5);
        add_cmd(K_INS_BACK, 0, W_MAX);
        add_cmd(K_INS_FRONT, 0, W_MIN);
        add_cmd(K_INS_AT, 2, -32'sd1);
        add_cmd(K_INS_AT, 1, 32'sd0);
        add_cmd(K_INS_BACK, 0, -32'sd1);
        add_cmd(K_GET, 0, 0);
        add_cmd(K_GET, 511, 0);
        add_cmd(K_SET, 1, W_MAX);
        add_cmd(K_FIND, 0, -32'sd1);
        add_cmd(K_FIND, 0, 32'sd12345);
        add_cmd(K_COUNT, 0, W_MAX);
        add_cmd(K_DEL_FIRST, 0, 32'sd12345);
        add_cmd(K_DEL_FIRST, 0, W_MAX);
        add_cmd(K_DEL_ALL, 0, -32'sd1);
        add_cmd(K_REVERSE, 0, 0);
        add_cmd(K_DEL_AT, 0, 0);
        add_cmd(K_SPARE_LO, 0, W_MIN);
        add_cmd(K_SPARE_HI, 511, -32'sd1);

        // Fill the list to capacity, then probe the full and last-index cases.
        add_cmd(K_CLEAR, 0, 0);
        repeat (CAPACITY) add_cmd(pick_insert_kind(), $urandom_range(gen_len), pick_value());
        add_cmd(K_INS_FRONT, 0, pick_value());
        add_cmd(K_INS_BACK, 0, pick_value());
        add_cmd(K_INS_AT, 0, pick_value());
        add_cmd(K_INS_AT, 300, pick_value());
        add_cmd(K_GET, CAPACITY - 1, 0);
        add_cmd(K_GET, CAPACITY, 0);
        add_cmd(K_SET, CAPACITY - 1, W_MIN);
        add_cmd(K_FIND, 0, W_MIN);
        add_cmd(K_COUNT, 0, key_pool[$urandom_range(7)]);
        add_cmd(K_REVERSE, 0, 0);
        add_cmd(K_DEL_AT, CAPACITY - 1, 0);
        add_cmd(K_INS_AT, CAPACITY - 1, W_MAX);
        add_cmd(K_DEL_ALL, 0, key_pool[$urandom_range(7)]);
        gen_burst(BURST_SHRINK, 40);

        // Random bursts of growth, mixed traffic and shrinking.
        while (pending_cmds.size() < DIRECTED_ROOM + RANDOM_ITEMS) begin
            case ($urandom_range(99) / 35)
                0:       gen_burst(BURST_GROW, $urandom_range(10, 50));
                1:       gen_burst(BURST_MIX, $urandom_range(10, 50));
                default: gen_burst(BURST_SHRINK, $urandom_range(10, 50));
            endcase
        end
        cmd_total = pending_cmds.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled away from the active edge so that driver updates have settled.
        do @(negedge i_clk); while (pending_cmds.size() != 0 || cmd_ch.valid);
        do @(negedge i_clk); while (expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
